[rtl/firc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// firc_pkg: shared types and constants of the circular FIR filter
// Register map codes, default parameter values and the per-cell control group.
// ----------------------------------------------------------------------------
package firc_pkg;

    localparam int DEF_MAX_TAPS    = 64;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_COEF_BITS   = 18;

    localparam int TAP_CFG_W     = 7;
    localparam int IDX_CFG_W     = 6;
    localparam int TAP_COUNT_RST = 64;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_TAP_COUNT  = 2'd0,
        REG_COEF_INDEX = 2'd1,
        REG_COEF_VALUE = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                 shift;
        logic                 rotate;
        logic                 clear;
        logic                 coef_we;
        logic [IDX_CFG_W-1:0] coef_idx;
    } t_cell_ctrl;

endpackage
`default_nettype wire

[rtl/fir_filter_circular.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_filter_circular: direct-form FIR filter, one shared MAC over a tap chain
// Samples and coefficients sit in a row of cells; the row rotates past a
// single multiply-accumulate once per item. Coefficients load through an
// index/value register pair; writing the tap count clears the delay line.
// ----------------------------------------------------------------------------
// Sequence: an accepted item walks S_RUN, S_TAIL and S_ROUND, then loads the
// output register. o_stall holds new items off until then, so the full rotation
//   of the cell row through the single multiplier ends before the next item.
// Reset (synchronous, active low): delay line and coefficients cleared, tap
//   count MAX_TAPS (at most 64), no item in flight.
// ----------------------------------------------------------------------------
module fir_filter_circular #(
    parameter int MAX_TAPS    = firc_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = firc_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = firc_pkg::DEF_COEF_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [firc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [firc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [firc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import firc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TAPS);
    localparam int TC_W  = $clog2(MAX_TAPS + 1);
    localparam logic [TC_W-1:0] TC_RST =
        TC_W'((TAP_COUNT_RST > MAX_TAPS) ? MAX_TAPS : TAP_COUNT_RST);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_TAIL,
        S_ROUND
    } t_state;

    t_state                        r_state;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic [TC_W-1:0]               r_tap_count;
    logic [IDX_CFG_W-1:0]          r_coef_index;
    logic signed [COEF_BITS-1:0]   r_coef_value;

    logic                          cfg_wr;
    t_reg_idx                      reg_sel;
    logic [TAP_CFG_W-1:0]          tap_wdata;
    logic [TC_W-1:0]               tap_clamped;
    logic                          in_acc;
    logic                          out_load;
    logic                          prod_en;
    logic                          prod_vld;
    logic signed [SAMPLE_BITS-1:0] mac_result;
    t_cell_ctrl                    cell_ctrl;

    logic signed [SAMPLE_BITS-1:0] smp  [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   coef [MAX_TAPS];

    // configuration port
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_sel   = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign tap_wdata = pwdata[TAP_CFG_W-1:0];

    always_comb begin
        if (tap_wdata == '0) begin
            tap_clamped = TC_W'(1);
        end else if (32'(tap_wdata) > 32'(MAX_TAPS)) begin
            tap_clamped = TC_W'(MAX_TAPS);
        end else begin
            tap_clamped = TC_W'(tap_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= TC_RST;
            r_coef_index <= '0;
            r_coef_value <= '0;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_TAP_COUNT:  r_tap_count  <= tap_clamped;
                REG_COEF_INDEX: r_coef_index <= pwdata[IDX_CFG_W-1:0];
                REG_COEF_VALUE: r_coef_value <= pwdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TAP_COUNT:  prdata = APB_DATA_W'(r_tap_count);
            REG_COEF_INDEX: prdata = APB_DATA_W'(r_coef_index);
            REG_COEF_VALUE: prdata = APB_DATA_W'(r_coef_value);
            default:        prdata = '0;
        endcase
    end

    // cell row
    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign prod_en = (r_state == S_RUN) && (TC_W'(r_cnt) < r_tap_count);

    assign cell_ctrl.shift    = in_acc;
    assign cell_ctrl.rotate   = (r_state == S_RUN);
    assign cell_ctrl.clear    = cfg_wr && (reg_sel == REG_TAP_COUNT);
    assign cell_ctrl.coef_we  = cfg_wr && (reg_sel == REG_COEF_VALUE);
    assign cell_ctrl.coef_idx = r_coef_index;

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] prev_smp;
        if (g == 0) begin : g_head
            assign prev_smp = i_sample_in;
        end else begin : g_body
            assign prev_smp = smp[g-1];
        end
        firc_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_prev_smp   (prev_smp),
            .i_next_smp   (smp[(g + 1) % MAX_TAPS]),
            .i_next_coef  (coef[(g + 1) % MAX_TAPS]),
            .i_coef_wdata (pwdata[COEF_BITS-1:0]),
            .o_smp        (smp[g]),
            .o_coef       (coef[g])
        );
    end

    firc_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (in_acc),
        .i_prod_en  (prod_en),
        .i_sample   (smp[0]),
        .i_coef     (coef[0]),
        .o_result   (mac_result),
        .o_prod_vld (prod_vld)
    );

    // sequencer and output register
    assign out_load = (r_state == S_ROUND) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MAX_TAPS - 1)) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= mac_result;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("block free right after taking an item");

    a_prod_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prod_vld |-> (r_state == S_RUN || r_state == S_TAIL))
        else $error("product valid outside the tap walk");

    a_load_from_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_ROUND)
        else $error("result loaded before the sum finished");

endmodule
`default_nettype wire

[rtl/firc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// firc_cell: one tap of the delay line
// Holds one sample and one coefficient. Shifts samples toward older taps on a
// new item and rotates both values toward cell 0 while the sum is walked.
// ----------------------------------------------------------------------------
module firc_cell #(
    parameter int SAMPLE_BITS = firc_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = firc_pkg::DEF_COEF_BITS,
    parameter int CELL_IDX    = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  firc_pkg::t_cell_ctrl          i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_smp,
    input  logic signed [SAMPLE_BITS-1:0] i_next_smp,
    input  logic signed [COEF_BITS-1:0]   i_next_coef,
    input  logic signed [COEF_BITS-1:0]   i_coef_wdata,
    output logic signed [SAMPLE_BITS-1:0] o_smp,
    output logic signed [COEF_BITS-1:0]   o_coef
);
    import firc_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic signed [COEF_BITS-1:0]   r_coef;
    logic                          coef_hit;

    assign coef_hit = i_ctrl.coef_we && (32'(i_ctrl.coef_idx) == 32'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp  <= '0;
            r_coef <= '0;
        end else begin
            if (i_ctrl.clear) begin
                r_smp <= '0;
            end else if (i_ctrl.shift) begin
                r_smp <= i_prev_smp;
            end else if (i_ctrl.rotate) begin
                r_smp <= i_next_smp;
            end
            if (coef_hit) begin
                r_coef <= i_coef_wdata;
            end else if (i_ctrl.rotate) begin
                r_coef <= i_next_coef;
            end
        end
    end

    assign o_smp  = r_smp;
    assign o_coef = r_coef;

endmodule
`default_nettype wire

[rtl/firc_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// firc_mac: shared multiply-accumulate and output rounding
// Registered product, accumulator, then round-half-up and saturate to the
// sample format.
// ----------------------------------------------------------------------------
module firc_mac #(
    parameter int MAX_TAPS    = firc_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = firc_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = firc_pkg::DEF_COEF_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_prod_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    output logic signed [SAMPLE_BITS-1:0] o_result,
    output logic                          o_prod_vld
);
    import firc_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int ACC_W  = (SUM_W > 64) ? 64 : SUM_W;
    localparam int FRAC   = COEF_BITS - 1;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_v;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_prod_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    always_comb begin
        rnd = r_acc + RND_HALF;
        shf = rnd >>> FRAC;
        if (shf > SAT_HI) begin
            o_result = SAMPLE_BITS'(SAT_HI);
        end else if (shf < SAT_LO) begin
            o_result = SAMPLE_BITS'(SAT_LO);
        end else begin
            o_result = SAMPLE_BITS'(shf);
        end
    end

    assign o_prod_vld = r_prod_v;

endmodule
`default_nettype wire
